// ===== design/sau_pkg.sv =====
package sau_pkg;

    localparam int unsigned DATA_W            = 32;
    localparam int unsigned MODE_W            = 3;
    localparam int unsigned ERR_W             = 2;
    localparam int unsigned DEPTH_OUT_W       = 7;
    localparam int unsigned STACK_DEPTH_DEF   = 64;
    localparam int unsigned MIN_OPERANDS      = 2;
    localparam int unsigned DIV_CNT_W         = $clog2(DATA_W);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_SUB  = 3'd2,
        MODE_MUL  = 3'd3,
        MODE_DIV  = 3'd4,
        MODE_MOD  = 3'd5
    } t_mode;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK   = 2'd0,
        ERR_FEW  = 2'd1,
        ERR_ZERO = 2'd2,
        ERR_FULL = 2'd3
    } t_err;

    // SH_DOWN moves every entry one place deeper, SH_UP one place toward the top.
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_DOWN = 2'd1,
        SH_UP   = 2'd2
    } t_shift;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
    } t_div_rsp;

endpackage

// ===== design/sau_cell.sv =====
module sau_cell (
    input  logic                        i_clk,
    input  sau_pkg::t_shift             i_shift,
    input  logic [sau_pkg::DATA_W-1:0]  i_from_up,
    input  logic [sau_pkg::DATA_W-1:0]  i_from_down,
    output logic [sau_pkg::DATA_W-1:0]  o_value
);
    import sau_pkg::*;

    logic [DATA_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        case (i_shift)
            SH_DOWN: r_value <= i_from_up;
            SH_UP:   r_value <= i_from_down;
            default: r_value <= r_value;
        endcase
    end

    assign o_value = r_value;

endmodule

// ===== design/sau_divider.sv =====
module sau_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sau_pkg::t_div_req i_req,
    output sau_pkg::t_div_rsp o_rsp
);
    import sau_pkg::*;

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_den;
    logic                 r_qneg;
    logic                 r_rneg;

    logic                 w_nneg;
    logic                 w_dneg;
    logic [DATA_W:0]      w_trial;
    logic [DATA_W:0]      w_diff;

    assign w_nneg  = i_req.num[DATA_W-1];
    assign w_dneg  = i_req.den[DATA_W-1];
    assign w_trial = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= w_nneg ? (DATA_W'(0) - i_req.num) : i_req.num;
            r_den  <= w_dneg ? (DATA_W'(0) - i_req.den) : i_req.den;
            r_qneg <= w_nneg ^ w_dneg;
            r_rneg <= w_nneg;
        end else if (r_run) begin
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_qneg ? (DATA_W'(0) - r_quo) : r_quo;
    assign o_rsp.rem  = r_rneg ? (DATA_W'(0) - r_rem) : r_rem;

endmodule

// ===== design/stack_arithmetic_unit.sv =====
// Push, add, sub and mul: the result strobe comes in the cycle after the transfer,
// and a new item may be started in the strobe cycle, so these run at one item per cycle.
// Div and mod go through a radix-2 iterative divider; busy stays high from the transfer until
// the strobe, so no item is taken during a divide and the divider sets the worst-case rate.
// The result cannot be stalled; it is shown for exactly one cycle.
// Synchronous active-low reset empties the stack; entry contents are not cleared.
module stack_arithmetic_unit #(
    parameter int unsigned STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [sau_pkg::MODE_W-1:0]           i_mode,
    input  logic signed [sau_pkg::DATA_W-1:0]    i_push_value,
    output logic                                 o_result_valid,
    output logic signed [sau_pkg::DATA_W-1:0]    o_top_value,
    output logic [sau_pkg::DEPTH_OUT_W-1:0]      o_stack_depth,
    output logic [sau_pkg::ERR_W-1:0]            o_error_code
);
    import sau_pkg::*;

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_valid;
    logic              n_valid;
    t_err              r_err;
    t_err              n_err;
    logic              r_is_mod;

    logic              w_accept;
    t_mode             w_mode;
    logic              w_full;
    logic              w_few;
    logic              w_div_go;
    t_shift            w_shift;
    logic [DATA_W-1:0] w_load;
    logic [DATA_W-1:0] w_alu;
    logic [DATA_W-1:0] w_a;
    logic [DATA_W-1:0] w_b;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    logic [DATA_W-1:0] w_cell [STACK_DEPTH];

    assign w_accept = start && !busy;
    assign w_mode   = t_mode'(i_mode);
    assign w_full   = (r_count == CNT_W'(STACK_DEPTH));
    assign w_few    = (r_count < CNT_W'(MIN_OPERANDS));
    assign w_a      = w_cell[0];
    assign w_b      = w_cell[1];
    assign w_div_go = w_accept && (w_mode == MODE_DIV || w_mode == MODE_MOD)
                      && !w_few && (w_a != '0);

    always_comb begin
        case (w_mode)
            MODE_ADD: w_alu = w_b + w_a;
            MODE_SUB: w_alu = w_b - w_a;
            MODE_MUL: w_alu = w_b * w_a;
            default:  w_alu = w_b + w_a;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_div_go) n_state = ST_DIV;
            ST_DIV:  if (w_div_rsp.done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Stack moves and result fields.
    always_comb begin
        w_shift           = SH_HOLD;
        w_load            = i_push_value;
        n_count           = r_count;
        n_valid           = 1'b0;
        n_err             = r_err;
        w_div_req.start   = 1'b0;
        w_div_req.num     = w_b;
        w_div_req.den     = w_a;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_valid = 1'b1;
                    n_err   = ERR_OK;
                    case (w_mode)
                        MODE_PUSH: begin
                            if (w_full) begin
                                n_err = ERR_FULL;
                            end else begin
                                w_shift = SH_DOWN;
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_ADD, MODE_SUB, MODE_MUL: begin
                            if (w_few) begin
                                n_err = ERR_FEW;
                            end else begin
                                w_shift = SH_UP;
                                w_load  = w_alu;
                                n_count = r_count - 1'b1;
                            end
                        end
                        MODE_DIV, MODE_MOD: begin
                            if (w_few) begin
                                n_err = ERR_FEW;
                            end else if (w_a == '0) begin
                                n_err = ERR_ZERO;
                            end else begin
                                n_valid         = 1'b0;
                                w_div_req.start = 1'b1;
                            end
                        end
                        default: n_err = ERR_OK;
                    endcase
                end
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    w_shift = SH_UP;
                    w_load  = r_is_mod ? w_div_rsp.rem : w_div_rsp.quo;
                    n_count = r_count - 1'b1;
                    n_valid = 1'b1;
                    n_err   = ERR_OK;
                end
            end
            default: w_shift = SH_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_err   <= ERR_OK;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_req.start) begin
            r_is_mod <= (w_mode == MODE_MOD);
        end
    end

    sau_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Entry 0 is the top of the stack. On a pop the top cell loads the result
    // while the cells below it move up by one.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_shift            w_op;
        logic [DATA_W-1:0] w_up;
        logic [DATA_W-1:0] w_down;

        if (g == 0) begin : g_top
            assign w_op = (w_shift == SH_UP) ? SH_DOWN : w_shift;
            assign w_up = w_load;
        end else begin : g_inner
            assign w_op = w_shift;
            assign w_up = w_cell[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_down = '0;
        end else begin : g_next
            assign w_down = w_cell[g+1];
        end

        sau_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_op),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_value     (w_cell[g])
        );
    end

    assign busy           = (r_state == ST_DIV);
    assign o_result_valid = r_valid;
    assign o_top_value    = (r_count == '0) ? '0 : w_cell[0];
    assign o_stack_depth  = DEPTH_OUT_W'(r_count);
    assign o_error_code   = r_err;

endmodule

// ===== design/sau_checker.sv =====
module sau_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_result_valid,
    input logic signed [sau_pkg::DATA_W-1:0] o_top_value,
    input logic [sau_pkg::DEPTH_OUT_W-1:0]  o_stack_depth,
    input logic [sau_pkg::ERR_W-1:0]        o_error_code
);
    import sau_pkg::*;

    // Every transfer either answers in the next cycle or starts a divide.
    a_answer_or_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_result_valid || busy)
        else $error("transfer neither answered nor started a divide");

    // The end of a divide always delivers its result.
    a_div_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("divide ended without a result");

    // A failed step leaves the stack depth unchanged.
    a_error_keeps_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_error_code != ERR_OK |-> $stable(o_stack_depth))
        else $error("stack depth changed on an error");

    // An empty stack shows a zero top.
    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_stack_depth == '0 |-> o_top_value == '0)
        else $error("nonzero top on an empty stack");

    // No strobe while a divide is still running.
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && $past(busy) |-> !o_result_valid)
        else $error("result strobe during a divide");

endmodule

bind stack_arithmetic_unit sau_checker u_sau_checker (.*);
